FILE: rtl/csag_pkg.sv
// ----------------------------------------------------------------------------
// csag_pkg
// item types, field widths and register indexes for the chunk scatter
// address generator
// ----------------------------------------------------------------------------
package csag_pkg;

    localparam int EXT_W      = 16;
    localparam int ROW_W      = 4;
    localparam int DEST_W     = 48;
    localparam int SRC_W      = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_DIM0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_DIM1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_DIM2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_DIM0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_DIM1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_DIM2  = 3'd6;

    typedef struct packed {
        logic [EXT_W-1:0] origin0;
        logic [EXT_W-1:0] origin1;
        logic [EXT_W-1:0] origin2;
    } t_in_item;

    typedef struct packed {
        logic [DEST_W-1:0] dest_index;
        logic [SRC_W-1:0]  src_offset;
        logic [EXT_W-1:0]  run_length;
        logic              last_run;
    } t_out_item;

endpackage

FILE: rtl/csag_mul.sv
// ----------------------------------------------------------------------------
// csag_mul
// shared unsigned 16 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
module csag_mul (
    input  logic                              i_clk,
    input  logic [csag_pkg::MUL_A_W-1:0]      i_a,
    input  logic [csag_pkg::MUL_B_W-1:0]      i_b,
    output logic [csag_pkg::PROD_W-1:0]       o_prod
);

    logic [csag_pkg::PROD_W-1:0] r_prod;
    logic [csag_pkg::PROD_W-1:0] n_prod;

    assign n_prod = csag_pkg::PROD_W'(i_a) * csag_pkg::PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/chunk_scatter_address_gen.sv
// ----------------------------------------------------------------------------
// chunk_scatter_address_gen
// clips one tile of a column-major array and emits one copy run per tile row
// ----------------------------------------------------------------------------
// usage
//   config channel: write a register index and data while the block is idle;
//   always ready, takes effect for the next tile
//   input channel: one item carries the origin of a tile; o_in_ready is high
//   only while the sequencer is idle, so one tile is handled at a time
//   output channel: one item per clipped tile row, rows of a plane first,
//   planes after, last_run marks the final run of the tile
// timing
//   an accepted tile passes the clip check, then S_MUL1 to S_MUL4 while
//   the shared multiplier forms the plane stride, row and plane start terms and tile
//   plane size; in S_EMIT the first run is loaded into the output register,
//   then one run per cycle while the receiver keeps up
//   a tile that starts outside the array goes from the clip check back to
//   idle and gives no run
// stalls and reset
//   runs wait in the output register while i_out_ready is low and emission
//   pauses; the next tile may be accepted while the last run still waits
//   reset empties the output register, returns the sequencer to idle and
//   sets the dimension count to 1 and every extent to 1
// ----------------------------------------------------------------------------
module chunk_scatter_address_gen #(
    parameter int MAX_DIMS       = 3,
    parameter int EXTENT_BITS    = 16,
    parameter int MAX_ROW_EXTENT = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [csag_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [csag_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // tile origins
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  csag_pkg::t_in_item                   i_in_item,
    // copy runs
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output csag_pkg::t_out_item                  o_out_item
);

    localparam int EW = $clog2(MAX_ROW_EXTENT + 1);              // row extent width
    localparam int CW = (MAX_ROW_EXTENT > 1) ? $clog2(MAX_ROW_EXTENT) : 1;
    localparam int XW = csag_pkg::EXT_W;
    localparam int DW = csag_pkg::DEST_W;
    localparam int SW = csag_pkg::SRC_W;

    localparam logic [XW-1:0] EXT_MASK = XW'((32'd1 << EXTENT_BITS) - 32'd1);
    localparam logic [1:0]    ND_MAX   = 2'(MAX_DIMS);
    localparam logic [EW-1:0] ROW_MAX  = EW'(MAX_ROW_EXTENT);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_MUL3  = 3'd4;
    localparam logic [2:0] S_MUL4  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // configuration registers
    logic [1:0]        r_dim_count;
    logic [XW-1:0]     r_array_dim0, r_array_dim1, r_array_dim2;
    logic [XW-1:0]     r_tile_dim0;
    logic [csag_pkg::ROW_W-1:0] r_tile_dim1, r_tile_dim2;

    // sequencer and working registers
    logic [2:0]        r_state, n_state;
    logic [XW-1:0]     r_org0, r_org1, r_org2;
    logic [XW-1:0]     r_clip0;
    logic [EW-1:0]     r_clip1, r_clip2;
    logic [31:0]       r_plane_stride;
    logic [SW-1:0]     r_tile_plane;
    logic [DW-1:0]     r_start;
    logic [DW-1:0]     r_dest_row, r_dest_plane;
    logic [SW-1:0]     r_src_row, r_src_plane;
    logic [CW-1:0]     r_row, r_plane;

    // output register
    logic                r_out_valid;
    csag_pkg::t_out_item r_out_item;

    // effective geometry
    logic [1:0]        w_nd;
    logic              w_used1, w_used2;
    logic [XW-1:0]     w_a0, w_a1, w_a2, w_t0;
    logic [EW-1:0]     w_t1, w_t2;

    // clip check
    logic [XW:0]       w_sum0, w_sum1, w_sum2;
    logic              w_bad;
    logic [XW-1:0]     w_c0;
    logic [EW-1:0]     w_c1, w_c2;

    // shared multiplier
    logic [csag_pkg::MUL_A_W-1:0] w_mul_a;
    logic [csag_pkg::MUL_B_W-1:0] w_mul_b;
    logic [csag_pkg::PROD_W-1:0]  w_prod;

    // run stepping
    logic              w_in_fire;
    logic              w_load;
    logic              w_row_end, w_last;
    logic [DW-1:0]     w_dest_next;
    logic [SW-1:0]     w_src_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count  <= 2'd1;
            r_array_dim0 <= XW'(1);
            r_array_dim1 <= XW'(1);
            r_array_dim2 <= XW'(1);
            r_tile_dim0  <= XW'(1);
            r_tile_dim1  <= csag_pkg::ROW_W'(1);
            r_tile_dim2  <= csag_pkg::ROW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                csag_pkg::CFG_DIM_COUNT:  r_dim_count  <= i_cfg_data[1:0];
                csag_pkg::CFG_ARRAY_DIM0: r_array_dim0 <= i_cfg_data;
                csag_pkg::CFG_ARRAY_DIM1: r_array_dim1 <= i_cfg_data;
                csag_pkg::CFG_ARRAY_DIM2: r_array_dim2 <= i_cfg_data;
                csag_pkg::CFG_TILE_DIM0:  r_tile_dim0  <= i_cfg_data;
                csag_pkg::CFG_TILE_DIM1:  r_tile_dim1  <= i_cfg_data[csag_pkg::ROW_W-1:0];
                csag_pkg::CFG_TILE_DIM2:  r_tile_dim2  <= i_cfg_data[csag_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // dimensions in use: zero counts as one, clamp at the build limit
    always_comb begin
        priority if (r_dim_count == 2'd0) begin
            w_nd = 2'd1;
        end else if (r_dim_count > ND_MAX) begin
            w_nd = ND_MAX;
        end else begin
            w_nd = r_dim_count;
        end
    end

    assign w_used1 = (w_nd >= 2'd2);
    assign w_used2 = (w_nd == 2'd3);

    // unused dimensions behave as extent one
    assign w_a0 = r_array_dim0 & EXT_MASK;
    assign w_a1 = w_used1 ? (r_array_dim1 & EXT_MASK) : XW'(1);
    assign w_a2 = w_used2 ? (r_array_dim2 & EXT_MASK) : XW'(1);
    assign w_t0 = r_tile_dim0 & EXT_MASK;

    // row extents saturate at the row limit
    assign w_t1 = !w_used1 ? EW'(1) :
                  (r_tile_dim1 > csag_pkg::ROW_W'(ROW_MAX)) ? ROW_MAX : EW'(r_tile_dim1);
    assign w_t2 = !w_used2 ? EW'(1) :
                  (r_tile_dim2 > csag_pkg::ROW_W'(ROW_MAX)) ? ROW_MAX : EW'(r_tile_dim2);

    // ------------------------------------------------------------------
    // clip against the array edges
    // ------------------------------------------------------------------
    assign w_sum0 = {1'b0, r_org0} + (XW + 1)'(w_t0);
    assign w_sum1 = {1'b0, r_org1} + (XW + 1)'(w_t1);
    assign w_sum2 = {1'b0, r_org2} + (XW + 1)'(w_t2);

    // tile starts outside the array, or has an empty dimension
    assign w_bad = (r_org0 >= w_a0) || (r_org1 >= w_a1) || (r_org2 >= w_a2) ||
                   (w_t0 == '0) || (w_t1 == '0) || (w_t2 == '0);

    assign w_c0 = (w_sum0 > {1'b0, w_a0}) ? (w_a0 - r_org0) : w_t0;
    assign w_c1 = (w_sum1 > {1'b0, w_a1}) ? EW'(w_a1 - r_org1) : w_t1;
    assign w_c2 = (w_sum2 > {1'b0, w_a2}) ? EW'(w_a2 - r_org2) : w_t2;

    // ------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb begin
        unique case (r_state)
            S_CHECK: begin
                w_mul_a = w_a0;
                w_mul_b = csag_pkg::MUL_B_W'(w_a1);
            end
            S_MUL1: begin
                w_mul_a = r_org1;
                w_mul_b = csag_pkg::MUL_B_W'(w_a0);
            end
            S_MUL2: begin
                w_mul_a = r_org2;
                w_mul_b = r_plane_stride;
            end
            S_MUL3: begin
                w_mul_a = w_t0;
                w_mul_b = csag_pkg::MUL_B_W'(w_t1);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    csag_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // ------------------------------------------------------------------
    // run stepping: a row or a plane step each for destination and source cursors
    // ------------------------------------------------------------------
    assign w_load    = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign w_row_end = ((EW'(r_row) + EW'(1)) == r_clip1);
    assign w_last    = w_row_end && ((EW'(r_plane) + EW'(1)) == r_clip2);

    // on a row wrap the next run starts one plane stride past the plane base
    assign w_dest_next = w_row_end ? (r_dest_plane + DW'(r_plane_stride))
                                   : (r_dest_row + DW'(w_a0));
    assign w_src_next  = w_row_end ? (r_src_plane + r_tile_plane)
                                   : (r_src_row + SW'(w_t0));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_fire) n_state = S_CHECK;
            S_CHECK: n_state = w_bad ? S_IDLE : S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_MUL4;
            S_MUL4:  n_state = S_EMIT;
            S_EMIT:  if (w_load && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_org0 <= i_in_item.origin0 & EXT_MASK;
            r_org1 <= w_used1 ? (i_in_item.origin1 & EXT_MASK) : '0;
            r_org2 <= w_used2 ? (i_in_item.origin2 & EXT_MASK) : '0;
        end
        unique case (r_state)
            S_CHECK: begin
                r_clip0 <= w_c0;
                r_clip1 <= w_c1;
                r_clip2 <= w_c2;
            end
            S_MUL1: begin
                // a0 * a1 ready
                r_plane_stride <= w_prod[31:0];
            end
            S_MUL2: begin
                // o1 * a0 ready
                r_start <= DW'(r_org0) + w_prod[DW-1:0];
            end
            S_MUL3: begin
                // o2 * plane stride ready
                r_start <= r_start + w_prod[DW-1:0];
            end
            S_MUL4: begin
                // t0 * t1 ready, cursors at the first run
                r_tile_plane <= w_prod[SW-1:0];
                r_dest_row   <= r_start;
                r_dest_plane <= r_start;
                r_src_row    <= '0;
                r_src_plane  <= '0;
                r_row        <= '0;
                r_plane      <= '0;
            end
            S_EMIT: begin
                if (w_load) begin
                    r_dest_row <= w_dest_next;
                    r_src_row  <= w_src_next;
                    if (w_row_end) begin
                        r_dest_plane <= w_dest_next;
                        r_src_plane  <= w_src_next;
                        r_row        <= '0;
                        r_plane      <= CW'(r_plane + 1'b1);
                    end else begin
                        r_row <= CW'(r_row + 1'b1);
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.dest_index <= r_dest_row;
            r_out_item.src_offset <= r_src_row;
            r_out_item.run_length <= r_clip0;
            r_out_item.last_run   <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((EW'(r_row) < r_clip1) && (EW'(r_plane) < r_clip2)))
        else $error("run counters beyond clipped extents");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_clip0 != '0) && (r_clip1 != '0) && (r_clip2 != '0)))
        else $error("emitting runs of an empty tile");

    a_last_ends_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> ((r_state == S_IDLE) && o_out_valid && o_out_item.last_run))
        else $error("final run did not end the tile");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("run shown outside emission");

endmodule
